[hdl/aac_pkg.sv]
// Shared types, widths and constants of the activity classifier.
`timescale 1ns / 1ps

package aac_pkg;

	// Field widths fixed by the sample and result formats
	localparam int SAMPLE_W     = 16;
	localparam int SUM_W        = 32;
	localparam int MAG_W        = 16;
	localparam int LEVEL_W      = 16;
	localparam int WEIGHT_FRAC  = 16;
	localparam int CFG_DATA_W   = 16;
	localparam int CFG_INDEX_W  = 2;
	localparam int CLASS_W      = 2;

	// Square root: one result bit per step
	localparam int ROOT_STEPS   = SUM_W / 2;
	localparam int ROOT_STEP_W  = $clog2(ROOT_STEPS);
	localparam int SHIFT_W      = $clog2(SUM_W);

	// Squaring pass over the three axes
	localparam int AXES         = 3;
	localparam int AXIS_W       = $clog2(AXES);

	// Defaults of the top level parameters
	localparam int DEF_FRACTION_BITS = 16;
	localparam int DEF_QUEUE_DEPTH   = 2;

	// Register reset values
	localparam logic [CFG_DATA_W-1:0] RST_GRAVITY = 16'd16384;
	localparam logic [CFG_DATA_W-1:0] RST_WALK    = 16'd1800;
	localparam logic [CFG_DATA_W-1:0] RST_RUN     = 16'd5000;
	localparam logic [CFG_DATA_W-1:0] RST_WEIGHT  = 16'd5243;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_GRAVITY = 2'd0,
		CFG_WALK    = 2'd1,
		CFG_RUN     = 2'd2,
		CFG_WEIGHT  = 2'd3
	} cfg_reg_t;

	typedef enum logic [CLASS_W-1:0] {
		ACT_SIT  = 2'd0,
		ACT_WALK = 2'd1,
		ACT_RUN  = 2'd2
	} activity_t;

	typedef struct packed {
		logic [CFG_DATA_W-1:0] gravity_offset;
		logic [CFG_DATA_W-1:0] walk_threshold;
		logic [CFG_DATA_W-1:0] run_threshold;
		logic [CFG_DATA_W-1:0] smoothing_weight;
	} cfg_regs_t;

	typedef enum logic [1:0] {
		FS_IDLE,
		FS_SQUARE,
		FS_PUSH
	} front_state_t;

	typedef enum logic [2:0] {
		BS_IDLE,
		BS_ROOT,
		BS_DIFF,
		BS_MUL,
		BS_UPDATE
	} back_state_t;

endpackage

[hdl/aac_ifaces.sv]
// Handshake channels: samples, results, configuration writes and the internal sum queue.
`timescale 1ns / 1ps

interface sample_if import aac_pkg::*; ();
	logic                       valid;
	logic                       ready;
	logic signed [SAMPLE_W-1:0] accel_x;
	logic signed [SAMPLE_W-1:0] accel_y;
	logic signed [SAMPLE_W-1:0] accel_z;

	modport source (output valid, accel_x, accel_y, accel_z, input ready);
	modport sink   (input valid, accel_x, accel_y, accel_z, output ready);
endinterface

interface result_if import aac_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [CLASS_W-1:0] activity_class;
	logic [LEVEL_W-1:0] smoothed_level;

	modport source (output valid, activity_class, smoothed_level, input ready);
	modport sink   (input valid, activity_class, smoothed_level, output ready);
endinterface

interface cfg_if import aac_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic [CFG_INDEX_W-1:0] index;
	logic [CFG_DATA_W-1:0]  data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

interface sum_if import aac_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [SUM_W-1:0] sum;

	modport source (output valid, sum, input ready);
	modport sink   (input valid, sum, output ready);
endinterface

[hdl/aac_front.sv]
// Front end: takes a sample and forms x*x + y*y + z*z with one shared multiplier.
`timescale 1ns / 1ps

module aac_front import aac_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	sample_if.sink  sample,
	sum_if.source   sum
);

	front_state_t               state_q, state_d;
	logic [AXIS_W-1:0]          axis_q;
	logic signed [SAMPLE_W-1:0] x_q, y_q, z_q;
	logic [SUM_W-1:0]           acc_q;
	logic signed [SAMPLE_W-1:0] operand;
	logic signed [SUM_W-1:0]    square;
	logic                       take;

	// Pick the axis for this squaring step
	always_comb begin
		case (axis_q)
			AXIS_W'(0): operand = x_q;
			AXIS_W'(1): operand = y_q;
			default:    operand = z_q;
		endcase
	end

	assign square = operand * operand;
	assign take   = sample.valid && sample.ready;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FS_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and handshakes
	always_comb begin
		state_d      = state_q;
		sample.ready = 1'b0;
		sum.valid    = 1'b0;
		case (state_q)
			FS_IDLE: begin
				sample.ready = 1'b1;
				if (sample.valid) state_d = FS_SQUARE;
			end
			FS_SQUARE: begin
				if (axis_q == AXIS_W'(AXES - 1)) state_d = FS_PUSH;
			end
			FS_PUSH: begin
				sum.valid = 1'b1;
				if (sum.ready) state_d = FS_IDLE;
			end
			default: state_d = FS_IDLE;
		endcase
	end

	// Capture the sample and accumulate squares
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			axis_q <= '0;
		end else if (take) begin
			axis_q <= '0;
		end else if (state_q == FS_SQUARE) begin
			axis_q <= axis_q + AXIS_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			x_q   <= sample.accel_x;
			y_q   <= sample.accel_y;
			z_q   <= sample.accel_z;
			acc_q <= '0;
		end else if (state_q == FS_SQUARE) begin
			acc_q <= acc_q + $unsigned(square);
		end
	end

	assign sum.sum = acc_q;

endmodule

[hdl/aac_queue.sv]
// Short queue of squared sums between the front and back ends.
`timescale 1ns / 1ps

module aac_queue import aac_pkg::*; #(
	parameter int DEPTH = DEF_QUEUE_DEPTH
) (
	input  logic  clk,
	input  logic  arst_n,
	sum_if.sink   push,
	sum_if.source pop
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [SUM_W-1:0] mem [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push, do_pop;

	assign push.ready = (count_q != CNT_W'(DEPTH));
	assign pop.valid  = (count_q != '0);
	assign pop.sum    = mem[rd_ptr_q];
	assign do_push    = push.valid && push.ready;
	assign do_pop     = pop.valid && pop.ready;

	// Store incoming beats
	always_ff @(posedge clk) begin
		if (do_push) mem[wr_ptr_q] <= push.sum;
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

[hdl/aac_back.sv]
// Back end: square root, gravity removal, exponential average and classification.
`timescale 1ns / 1ps

module aac_back import aac_pkg::*; #(
	parameter int FRACTION_BITS = DEF_FRACTION_BITS
) (
	input  logic      clk,
	input  logic      arst_n,
	input  cfg_regs_t regs,
	sum_if.sink       sum,
	result_if.source  result
);

	localparam int AVG_W  = LEVEL_W + FRACTION_BITS;
	localparam int PROD_W = AVG_W + WEIGHT_FRAC;

	back_state_t            state_q, state_d;
	logic [ROOT_STEP_W-1:0] step_q;
	logic [SUM_W-1:0]       rem_q, root_q;
	logic [AVG_W-1:0]       diff_q, avg_q;
	logic                   up_q;
	logic [PROD_W-1:0]      prod_q;
	logic                   res_valid_q;
	logic [CLASS_W-1:0]     class_q;
	logic [LEVEL_W-1:0]     level_q;

	logic [SUM_W-1:0]       bit_w, trial;
	logic                   fits;
	logic [MAG_W-1:0]       mag;
	logic [LEVEL_W-1:0]     motion;
	logic [AVG_W-1:0]       target, delta, avg_next, run_lim, walk_lim;
	logic                   up;
	activity_t              cls;
	logic                   load;

	// Square root step: test the current bit pair
	assign bit_w = SUM_W'(1) << (SHIFT_W'(SUM_W - 2) - {step_q, 1'b0});
	assign trial = root_q + bit_w;
	assign fits  = (rem_q >= trial);

	// Distance from one g and signed gap to the average
	assign mag    = root_q[MAG_W-1:0];
	assign motion = (mag >= regs.gravity_offset) ? mag - regs.gravity_offset
	                                             : regs.gravity_offset - mag;
	assign target = AVG_W'(motion) << FRACTION_BITS;
	assign up     = (target >= avg_q);

	// Average step and classification of the new level
	assign delta    = AVG_W'(prod_q >> WEIGHT_FRAC);
	assign avg_next = up_q ? avg_q + delta : avg_q - delta;
	assign run_lim  = AVG_W'(regs.run_threshold) << FRACTION_BITS;
	assign walk_lim = AVG_W'(regs.walk_threshold) << FRACTION_BITS;

	always_comb begin
		if (avg_next > run_lim) begin
			cls = ACT_RUN;
		end else if (avg_next > walk_lim) begin
			cls = ACT_WALK;
		end else begin
			cls = ACT_SIT;
		end
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BS_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state; hold the update while the result register is occupied and not taken
	always_comb begin
		state_d   = state_q;
		sum.ready = 1'b0;
		load      = 1'b0;
		case (state_q)
			BS_IDLE: begin
				sum.ready = 1'b1;
				if (sum.valid) state_d = BS_ROOT;
			end
			BS_ROOT: begin
				if (step_q == ROOT_STEP_W'(ROOT_STEPS - 1)) state_d = BS_DIFF;
			end
			BS_DIFF: state_d = BS_MUL;
			BS_MUL:  state_d = BS_UPDATE;
			BS_UPDATE: begin
				if (!res_valid_q || result.ready) begin
					load    = 1'b1;
					state_d = BS_IDLE;
				end
			end
			default: state_d = BS_IDLE;
		endcase
	end

	// Running average, result valid and square root step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			avg_q       <= '0;
			res_valid_q <= 1'b0;
			step_q      <= '0;
		end else begin
			if (load) begin
				avg_q <= avg_next;
			end
			if (load) begin
				res_valid_q <= 1'b1;
			end else if (result.ready) begin
				res_valid_q <= 1'b0;
			end
			if (state_q == BS_ROOT) begin
				step_q <= step_q + ROOT_STEP_W'(1);
			end else begin
				step_q <= '0;
			end
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			BS_IDLE: begin
				rem_q  <= sum.sum;
				root_q <= '0;
			end
			BS_ROOT: begin
				if (fits) begin
					rem_q  <= rem_q - trial;
					root_q <= (root_q >> 1) + bit_w;
				end else begin
					root_q <= root_q >> 1;
				end
			end
			BS_DIFF: begin
				up_q   <= up;
				diff_q <= up ? target - avg_q : avg_q - target;
			end
			BS_MUL: begin
				prod_q <= PROD_W'(diff_q) * PROD_W'(regs.smoothing_weight);
			end
			default: ;
		endcase
		if (load) begin
			class_q <= cls;
			level_q <= avg_next[AVG_W-1 -: LEVEL_W];
		end
	end

	assign result.valid          = res_valid_q;
	assign result.activity_class = class_q;
	assign result.smoothed_level = level_q;

endmodule

[hdl/accel_activity_classifier_top.sv]
// Top level of the accelerometer activity classifier: registers, front end, queue, back end.
//
//   channel  | role | payload
//   ---------+------+------------------------------------------------
//   sample   | sink | accel_x, accel_y, accel_z (signed 16 bits)
//   result   | src  | activity_class (2 bits), smoothed_level (16 bits)
//   cfg      | sink | index (2 bits), data (16 bits); ready always high
//
// The front end works through a sample in steps: capture, three squares, hand-off.
// The back end sets the rate: per sample it runs the bit-per-step square root in sixteen
// steps, then difference, multiply and update.
// A result waits in its output register; the back end stalls only at its update step.
// Reset clears the average to zero and loads register defaults.
`timescale 1ns / 1ps

module accel_activity_classifier_top import aac_pkg::*; #(
	parameter int FRACTION_BITS = DEF_FRACTION_BITS,
	parameter int QUEUE_DEPTH   = DEF_QUEUE_DEPTH
) (
	input  logic     clk,
	input  logic     arst_n,
	sample_if.sink   sample,
	result_if.source result,
	cfg_if.sink      cfg
);

	cfg_regs_t regs_q;

	sum_if sum_push ();
	sum_if sum_pop ();

	// Configuration register file
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.gravity_offset   <= RST_GRAVITY;
			regs_q.walk_threshold   <= RST_WALK;
			regs_q.run_threshold    <= RST_RUN;
			regs_q.smoothing_weight <= RST_WEIGHT;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg_reg_t'(cfg.index))
				CFG_GRAVITY: regs_q.gravity_offset   <= cfg.data;
				CFG_WALK:    regs_q.walk_threshold   <= cfg.data;
				CFG_RUN:     regs_q.run_threshold    <= cfg.data;
				CFG_WEIGHT:  regs_q.smoothing_weight <= cfg.data;
				default: ;
			endcase
		end
	end

	aac_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.sample (sample),
		.sum    (sum_push)
	);

	aac_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (sum_push),
		.pop    (sum_pop)
	);

	aac_back #(
		.FRACTION_BITS (FRACTION_BITS)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.regs   (regs_q),
		.sum    (sum_pop),
		.result (result)
	);

endmodule
